/* hdl/resistive_touch_qualifier_core_macros.svh */
// Assertion macros for the touch qualifier.
`ifndef RESISTIVE_TOUCH_QUALIFIER_CORE_MACROS_SVH
`define RESISTIVE_TOUCH_QUALIFIER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define RTQ_ASSERT_IMPLY(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("touch qualifier check failed");
`define RTQ_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("touch qualifier sequence check failed");
`else
`define RTQ_ASSERT_IMPLY(label, clk, rst, cond, prop)
`define RTQ_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

/* hdl/rtq_pkg.sv */
`default_nettype none
package rtq_pkg;

  localparam int RAW_W = 12;
  localparam int SCR_W = 16;
  localparam int CNT_W = 3;
  localparam int EV_W = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int SAMPLE_COUNT_DEF = 5;

  localparam logic [RAW_W-1:0] PRESS_LOW = 12'd100;
  localparam logic [RAW_W-1:0] PRESS_HIGH = 12'd1000;

  localparam logic [EV_W-1:0] EV_NONE = 2'd0;
  localparam logic [EV_W-1:0] EV_PRESS = 2'd1;
  localparam logic [EV_W-1:0] EV_HOLD = 2'd2;
  localparam logic [EV_W-1:0] EV_RELEASE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_RAW_LEFT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_RIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_TOP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_BOTTOM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_LEFT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_RIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_TOP = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_BOTTOM = 3'd7;

  localparam logic [RAW_W-1:0] RAW_LEFT_RST = 12'd0;
  localparam logic [RAW_W-1:0] RAW_RIGHT_RST = 12'd4095;
  localparam logic [RAW_W-1:0] RAW_TOP_RST = 12'd0;
  localparam logic [RAW_W-1:0] RAW_BOTTOM_RST = 12'd4095;
  localparam logic [SCR_W-1:0] SCREEN_LEFT_RST = 16'd0;
  localparam logic [SCR_W-1:0] SCREEN_RIGHT_RST = 16'd319;
  localparam logic [SCR_W-1:0] SCREEN_TOP_RST = 16'd0;
  localparam logic [SCR_W-1:0] SCREEN_BOTTOM_RST = 16'd239;

  // Dividend is |raw delta| * |screen delta|, divisor is |raw span|.
  localparam int DIVIDEND_W = RAW_W + SCR_W;
  localparam int DIVISOR_W = RAW_W;

  typedef struct packed {
    logic [RAW_W-1:0] sample_x;
    logic [RAW_W-1:0] sample_y;
    logic [RAW_W-1:0] pressure;
  } sample_t;

  typedef struct packed {
    logic [EV_W-1:0] event_res;
    logic [SCR_W-1:0] point_x;
    logic [SCR_W-1:0] point_y;
  } result_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_left;
    logic [RAW_W-1:0] raw_right;
    logic [RAW_W-1:0] raw_top;
    logic [RAW_W-1:0] raw_bottom;
    logic [SCR_W-1:0] screen_left;
    logic [SCR_W-1:0] screen_right;
    logic [SCR_W-1:0] screen_top;
    logic [SCR_W-1:0] screen_bottom;
  } cal_t;

endpackage
`default_nettype wire

/* hdl/rtq_cal_regs.sv */
`default_nettype none
module rtq_cal_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [rtq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rtq_pkg::CFG_DATA_W-1:0]    cfg_data,
  output rtq_pkg::cal_t                          cal
);
  import rtq_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal.raw_left <= RAW_LEFT_RST;
      cal.raw_right <= RAW_RIGHT_RST;
      cal.raw_top <= RAW_TOP_RST;
      cal.raw_bottom <= RAW_BOTTOM_RST;
      cal.screen_left <= SCREEN_LEFT_RST;
      cal.screen_right <= SCREEN_RIGHT_RST;
      cal.screen_top <= SCREEN_TOP_RST;
      cal.screen_bottom <= SCREEN_BOTTOM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RAW_LEFT: cal.raw_left <= cfg_data[RAW_W-1:0];
        REG_RAW_RIGHT: cal.raw_right <= cfg_data[RAW_W-1:0];
        REG_RAW_TOP: cal.raw_top <= cfg_data[RAW_W-1:0];
        REG_RAW_BOTTOM: cal.raw_bottom <= cfg_data[RAW_W-1:0];
        REG_SCREEN_LEFT: cal.screen_left <= cfg_data[SCR_W-1:0];
        REG_SCREEN_RIGHT: cal.screen_right <= cfg_data[SCR_W-1:0];
        REG_SCREEN_TOP: cal.screen_top <= cfg_data[SCR_W-1:0];
        REG_SCREEN_BOTTOM: cal.screen_bottom <= cfg_data[SCR_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/rtq_divider.sv */
`default_nettype none
module rtq_divider (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [rtq_pkg::DIVIDEND_W-1:0]    dividend,
  input  wire logic [rtq_pkg::DIVISOR_W-1:0]     divisor,
  output logic                                   done,
  output logic [rtq_pkg::DIVIDEND_W-1:0]         quotient
);
  import rtq_pkg::*;

  localparam int STEP_W = $clog2(DIVIDEND_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

  logic busy;
  logic [STEP_W-1:0] step;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dsr;
  logic [DIVISOR_W:0] shifted;
  logic [DIVISOR_W:0] trial;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    shifted = {rem, quotient[DIVIDEND_W-1]};
    trial = shifted - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (trial[DIVISOR_W]) begin
        rem <= shifted[DIVISOR_W-1:0];
      end else begin
        rem <= trial[DIVISOR_W-1:0];
      end
      quotient <= {quotient[DIVIDEND_W-2:0], ~trial[DIVISOR_W]};
    end
  end

endmodule
`default_nettype wire

/* hdl/resistive_touch_qualifier_core.sv */
`default_nettype none
// Resistive touch qualifier. Each sample item gives exactly one result item carrying
// the press event and the stored screen point. A sample that does not leave the
// debounce counter at full count goes straight to the output stage, from which its
// result is loaded into the output register. A sample that leaves the debounce
// counter at full count maps both coordinates in turn through one shared multiplier
// and one shared serial divider that yields one quotient bit per cycle over 28 bits;
// each coordinate passes the setup states (prepare, multiply, start), the division
// up to its done pulse, and a fix step that applies the sign and offset. The block
// accepts one item at a time and holds sample_stall high until the result is loaded
// into the output register; a stalled result adds its stall cycles to the item.
// Calibration registers are to be written only while the block is idle; the block
// itself does not enforce this.
`include "resistive_touch_qualifier_core_macros.svh"
module resistive_touch_qualifier_core #(
  parameter int SAMPLE_COUNT = rtq_pkg::SAMPLE_COUNT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              sample_valid,
  output logic                                   sample_stall,
  input  wire rtq_pkg::sample_t                  sample,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output rtq_pkg::result_t                       result,
  input  wire logic                              cfg_we,
  input  wire logic [rtq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rtq_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rtq_pkg::*;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(SAMPLE_COUNT);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_MUL = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_DIV = 3'd4;
  localparam logic [2:0] S_FIX = 3'd5;
  localparam logic [2:0] S_OUT = 3'd6;

  cal_t cal;
  logic [2:0] state;
  logic [2:0] state_next;
  logic accept;
  logic load;
  logic pressed;
  logic [CNT_W-1:0] press_count;
  logic [CNT_W-1:0] press_count_next;
  logic held;
  logic held_next;
  logic [EV_W-1:0] ev;
  logic [EV_W-1:0] ev_next;
  logic [SCR_W-1:0] mapped_x;
  logic [SCR_W-1:0] mapped_y;
  logic [RAW_W-1:0] smp_x;
  logic [RAW_W-1:0] smp_y;
  logic coord;

  logic [RAW_W-1:0] sel_v;
  logic [RAW_W-1:0] sel_ra;
  logic [RAW_W-1:0] sel_rb;
  logic [SCR_W-1:0] sel_sa;
  logic [SCR_W-1:0] sel_sb;
  logic [RAW_W:0] dv;
  logic [SCR_W:0] ds;
  logic [RAW_W:0] dspan;

  logic [RAW_W-1:0] mag_v;
  logic [SCR_W-1:0] mag_s;
  logic [RAW_W-1:0] mag_span;
  logic neg;
  logic span_zero;
  logic [DIVIDEND_W-1:0] prod;
  logic div_done;
  logic [DIVIDEND_W-1:0] div_quo;
  logic [SCR_W-1:0] q_low;
  logic [SCR_W-1:0] q_signed;
  logic [SCR_W-1:0] map_val;

  rtq_cal_regs u_cal (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cal       (cal)
  );

  rtq_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_START),
    .dividend (prod),
    .divisor  (mag_span),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign sample_stall = (state != S_IDLE);
  assign accept = sample_valid && !sample_stall;
  assign load = (state == S_OUT) && (!result_valid || !result_stall);

  always_comb begin
    pressed = (sample.pressure > PRESS_LOW) && (sample.pressure < PRESS_HIGH);
    press_count_next = press_count;
    if (pressed) begin
      if (press_count < FULL_COUNT) begin
        press_count_next = press_count + 1'b1;
      end
    end else if (press_count != '0) begin
      press_count_next = press_count - 1'b1;
    end
    held_next = held;
    ev_next = EV_NONE;
    if (press_count_next == FULL_COUNT && !held) begin
      held_next = 1'b1;
      ev_next = EV_PRESS;
    end else if (held) begin
      if (press_count_next == '0) begin
        held_next = 1'b0;
        ev_next = EV_RELEASE;
      end else if (press_count_next == FULL_COUNT) begin
        ev_next = EV_HOLD;
      end
    end
  end

  always_comb begin
    if (!coord) begin
      sel_v = smp_y;
      sel_ra = cal.raw_left;
      sel_rb = cal.raw_right;
      sel_sa = cal.screen_left;
      sel_sb = cal.screen_right;
    end else begin
      sel_v = smp_x;
      sel_ra = cal.raw_top;
      sel_rb = cal.raw_bottom;
      sel_sa = cal.screen_top;
      sel_sb = cal.screen_bottom;
    end
    dv = {1'b0, sel_v} - {1'b0, sel_ra};
    ds = {1'b0, sel_sb} - {1'b0, sel_sa};
    dspan = {1'b0, sel_rb} - {1'b0, sel_ra};
    q_low = div_quo[SCR_W-1:0];
    q_signed = neg ? (~q_low + 1'b1) : q_low;
    map_val = span_zero ? '0 : (q_signed + sel_sa);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (pressed && press_count_next == FULL_COUNT) begin
            state_next = S_PREP;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_PREP: state_next = S_MUL;
      S_MUL: state_next = S_START;
      S_START: state_next = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_next = S_FIX;
        end
      end
      S_FIX: state_next = coord ? S_OUT : S_PREP;
      S_OUT: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      press_count <= '0;
      held <= 1'b0;
      mapped_x <= '0;
      mapped_y <= '0;
      coord <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        press_count <= press_count_next;
        held <= held_next;
        coord <= 1'b0;
      end
      if (state == S_FIX) begin
        coord <= 1'b1;
        if (!coord) begin
          mapped_x <= map_val;
        end else begin
          mapped_y <= map_val;
        end
      end
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ev <= ev_next;
      smp_x <= sample.sample_x;
      smp_y <= sample.sample_y;
    end
    if (state == S_PREP) begin
      mag_v <= dv[RAW_W] ? RAW_W'(-dv) : dv[RAW_W-1:0];
      mag_s <= ds[SCR_W] ? SCR_W'(-ds) : ds[SCR_W-1:0];
      mag_span <= dspan[RAW_W] ? RAW_W'(-dspan) : dspan[RAW_W-1:0];
      neg <= dv[RAW_W] ^ ds[SCR_W] ^ dspan[RAW_W];
      span_zero <= (dspan == '0);
    end
    if (state == S_MUL) begin
      prod <= DIVIDEND_W'(mag_v) * DIVIDEND_W'(mag_s);
    end
    if (load) begin
      result.event_res <= ev;
      result.point_x <= mapped_x;
      result.point_y <= mapped_y;
    end
  end

  `RTQ_ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, state != S_IDLE)
  `RTQ_ASSERT_NEXT(a_result_after_load, clk, rst, load, result_valid)
  `RTQ_ASSERT_IMPLY(a_held_nonzero, clk, rst, held, press_count != '0)
  `RTQ_ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, press_count <= FULL_COUNT)

endmodule
`default_nettype wire
